// ----- design/radix_integer_formatter_macros.svh -----
// Assertion macros used by the radix integer formatter datapath.
`ifndef RADIX_INTEGER_FORMATTER_MACROS_SVH
`define RADIX_INTEGER_FORMATTER_MACROS_SVH

// Invariant checked on every clock edge out of reset.
`define RIF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define RIF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rif_pkg.sv -----
// Shared types, constants and helper functions of the radix integer formatter.
`timescale 1ns / 1ps

package rif_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam logic [3:0] TEN        = 4'd10;
  // ceil(2^35 / 10): q = (v * RECIP10) >> 35 is exact for any 32-bit v
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    MODE_BIN = 2'd0,
    MODE_OCT = 2'd1,
    MODE_DEC = 2'd2,
    MODE_HEX = 2'd3
  } radix_mode_t;

  // datapath actions
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_QUOT,
    ACT_DIGIT,
    ACT_CALC,
    ACT_PAD,
    ACT_FETCH,
    ACT_EMIT
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_MORE_DIG,
    CND_NO_PAD,
    CND_MORE_PAD,
    CND_DIG_LEFT
  } cond_t;

  // microprogram addresses
  typedef enum logic [3:0] {
    PC_IDLE,
    PC_QUOT,
    PC_DIGIT,
    PC_CALC,
    PC_PADCHK,
    PC_PADOUT,
    PC_FETCH,
    PC_DIGOUT,
    PC_END
  } upc_t;

  typedef struct packed {
    act_t  act;
    logic  wait_in;
    logic  wait_out;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    act_t act;
  } ctrl_t;

  typedef struct packed {
    logic more_dig;
    logic no_pad;
    logic more_pad;
    logic dig_left;
    logic out_free;
  } status_t;

  function automatic logic [4:0] radix_of(input radix_mode_t m);
    logic [4:0] r;
    unique case (m)
      MODE_BIN: r = 5'd2;
      MODE_OCT: r = 5'd8;
      MODE_DEC: r = 5'd10;
      MODE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  // shift amount for the power-of-two radices
  function automatic logic [2:0] shift_of(input radix_mode_t m);
    logic [2:0] s;
    unique case (m)
      MODE_BIN: s = 3'd1;
      MODE_OCT: s = 3'd3;
      MODE_HEX: s = 3'd4;
      default:  s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d <= DIGIT_MAX) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d - TEN};
    end
    return c;
  endfunction

endpackage

// ----- design/rif_sequencer.sv -----
// Microprogram ROM, step counter and jump logic of the radix integer formatter.
`timescale 1ns / 1ps

module rif_sequencer
  import rif_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  status_t st,
  output ctrl_t   ctrl,
  output logic    idle
);

  upc_t   pc;
  upc_t   pc_next;
  uword_t word;
  logic   hold;
  logic   taken;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    unique case (a)
      PC_IDLE:   w = '{act: ACT_LOAD,  wait_in: 1'b1, wait_out: 1'b0,
                       cond: CND_NEXT,     target: PC_IDLE};
      PC_QUOT:   w = '{act: ACT_QUOT,  wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_NEXT,     target: PC_IDLE};
      PC_DIGIT:  w = '{act: ACT_DIGIT, wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_MORE_DIG, target: PC_QUOT};
      PC_CALC:   w = '{act: ACT_CALC,  wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_NEXT,     target: PC_IDLE};
      PC_PADCHK: w = '{act: ACT_NONE,  wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_NO_PAD,   target: PC_FETCH};
      PC_PADOUT: w = '{act: ACT_PAD,   wait_in: 1'b0, wait_out: 1'b1,
                       cond: CND_MORE_PAD, target: PC_PADOUT};
      PC_FETCH:  w = '{act: ACT_FETCH, wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_NEXT,     target: PC_IDLE};
      PC_DIGOUT: w = '{act: ACT_EMIT,  wait_in: 1'b0, wait_out: 1'b1,
                       cond: CND_DIG_LEFT, target: PC_FETCH};
      PC_END:    w = '{act: ACT_NONE,  wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_ALWAYS,   target: PC_IDLE};
      default:   w = '{act: ACT_NONE,  wait_in: 1'b0, wait_out: 1'b0,
                       cond: CND_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = ucode(pc);
    hold = (word.wait_in && !req_valid) || (word.wait_out && !st.out_free);
    unique case (word.cond)
      CND_NEXT:     taken = 1'b0;
      CND_ALWAYS:   taken = 1'b1;
      CND_MORE_DIG: taken = st.more_dig;
      CND_NO_PAD:   taken = st.no_pad;
      CND_MORE_PAD: taken = st.more_pad;
      CND_DIG_LEFT: taken = st.dig_left;
      default:      taken = 1'b1;
    endcase
    if (hold) begin
      pc_next  = pc;
      ctrl.act = ACT_NONE;
    end else begin
      pc_next  = taken ? word.target : upc_t'(pc + 4'd1);
      ctrl.act = word.act;
    end
  end

  assign idle = (pc == PC_IDLE);

endmodule

// ----- design/rif_datapath.sv -----
// Digit extraction, digit buffer, padding counter and output register.
`timescale 1ns / 1ps
`include "radix_integer_formatter_macros.svh"

module rif_datapath
  import rif_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32,
  parameter int MAX_FIELD  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  output status_t     st,
  input  logic [31:0] value,
  input  logic [1:0]  mode,
  input  logic [5:0]  min_width,
  input  logic        zero_pad,
  output logic        char_valid,
  input  logic        char_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int NDW = $clog2(MAX_DIGITS + 1);
  localparam int AW  = $clog2(MAX_DIGITS);
  localparam int CW  = 7;

  logic [VW-1:0] v;
  logic [VW-1:0] q;
  logic [VW-1:0] q_next;
  logic [VW-1:0] qr;
  logic [VW-1:0] diff;
  logic [3:0]    rem;
  logic [63:0]   prod;
  radix_mode_t   mode_r;
  logic [5:0]    width_r;
  logic [5:0]    width_sat;
  logic          zpad_r;
  logic [NDW-1:0] ndig;
  logic [5:0]    pad;
  logic [5:0]    pad_calc;
  logic [7:0]    rd_data;
  logic          out_free;
  logic [7:0]    dig_mem [MAX_DIGITS];

  // quotient: reciprocal multiply for decimal, shift otherwise
  always_comb begin
    prod   = {32'd0, 32'(v)} * {32'd0, RECIP10};
    q_next = (mode_r == MODE_DEC) ? VW'(prod[63:RECIP_SHIFT]) : (v >> shift_of(mode_r));
    if (mode_r == MODE_DEC) begin
      qr = VW'({q, 3'b000}) + VW'({q, 1'b0});
    end else begin
      qr = q << shift_of(mode_r);
    end
    diff = v - qr;
    rem  = diff[3:0];
  end

  assign width_sat = ({1'b0, min_width} > CW'(MAX_FIELD)) ? 6'(MAX_FIELD) : min_width;
  assign pad_calc  = (CW'(width_r) > CW'(ndig)) ? 6'(CW'(width_r) - CW'(ndig)) : 6'd0;
  assign out_free  = !char_valid || !char_stall;

  always_comb begin
    st.more_dig = (q != '0) && (CW'(ndig) + CW'(1) < CW'(MAX_DIGITS));
    st.no_pad   = (pad == 6'd0);
    st.more_pad = (pad > 6'd1);
    st.dig_left = (ndig != '0);
    st.out_free = out_free;
  end

  // operand and quotient registers
  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_LOAD: begin
        v       <= value[VW-1:0];
        mode_r  <= radix_mode_t'(mode);
        width_r <= width_sat;
        zpad_r  <= zero_pad;
      end
      ACT_QUOT:  q <= q_next;
      ACT_DIGIT: v <= q;
      default: ;
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ndig <= '0;
      pad  <= '0;
    end else begin
      case (ctrl.act)
        ACT_LOAD:  ndig <= '0;
        ACT_DIGIT: ndig <= ndig + NDW'(1);
        ACT_CALC:  pad  <= pad_calc;
        ACT_PAD:   pad  <= pad - 6'd1;
        ACT_FETCH: ndig <= ndig - NDW'(1);
        default: ;
      endcase
    end
  end

  // digit buffer, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_DIGIT) begin
      dig_mem[ndig[AW-1:0]] <= digit_char(rem);
    end
    if (ctrl.act == ACT_FETCH) begin
      rd_data <= dig_mem[AW'(ndig - NDW'(1))];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (ctrl.act == ACT_PAD || ctrl.act == ACT_EMIT) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_PAD) begin
      out_char <= zpad_r ? CHAR_ZERO : CHAR_SPACE;
      last     <= 1'b0;
    end else if (ctrl.act == ACT_EMIT) begin
      out_char <= rd_data;
      last     <= (ndig == '0);
    end
  end

  `RIF_ASSERT_ALWAYS(a_ndig_bound, CW'(ndig) <= CW'(MAX_DIGITS), "digit count overflow")
  `RIF_ASSERT_IMP(a_rem_range, ctrl.act == ACT_DIGIT, 5'(rem) < radix_of(mode_r), "remainder out of range")
  `RIF_ASSERT_NEXT(a_pad_not_last, ctrl.act == ACT_PAD, !last, "pad character flagged last")

endmodule

// ----- design/radix_integer_formatter.sv -----
// Top level of the radix integer formatter: sequencer plus datapath.
`timescale 1ns / 1ps

// Formats an unsigned value in radix 2, 8, 10 or 16 and sends it out as
// ASCII characters, most significant first, one character per request on
// the output channel. When min_width (saturated at MAX_FIELD) exceeds the
// digit count, pad characters (space, or '0' with zero_pad) come first.
// Hex letters are upper case, zero prints as a single '0', and the final
// character carries last. Only the low VALUE_BITS bits of value are used;
// at most MAX_DIGITS low-order digits are kept. One request is taken at a
// time: req_stall is low only while the microprogram sits at its idle
// step, and the next request can be taken while the final character still
// waits in the output register.
// The microprogram runs one control word per cycle, except while it holds
// at the idle step for a request or at an output step for a free output
// register; each digit costs two steps to extract (a reciprocal multiply
// by 1/10 or a shift, then the remainder) and two to send (buffer read,
// then output load).

module radix_integer_formatter
  import rif_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32,
  parameter int MAX_FIELD  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] value,
  input  logic [1:0]  mode,
  input  logic [5:0]  min_width,
  input  logic        zero_pad,
  output logic        char_valid,
  input  logic        char_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  ctrl_t   ctrl;
  status_t st;
  logic    idle;

  // microprogram: one control word per step, conditional jumps on status
  rif_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .st        (st),
    .ctrl      (ctrl),
    .idle      (idle)
  );

  // request is taken only at the idle step
  assign req_stall = !idle;

  rif_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_FIELD  (MAX_FIELD)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .st         (st),
    .value      (value),
    .mode       (mode),
    .min_width  (min_width),
    .zero_pad   (zero_pad),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last       (last)
  );

endmodule

// ----- dv/tb_radix_integer_formatter.sv -----
// Testbench for radix_integer_formatter: random and directed requests checked per character.
`timescale 1ns / 1ps

module tb_radix_integer_formatter;
  import rif_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_COUNT = 100;
  // The final stretch of requests runs with no idling on either side.
  localparam int QUIET_COUNT  = 20;
  // Request index that triggers the long receiver hold-off.
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 300;
  // Longest correct run of cycles with nothing accepted:
  //   the hold-off, plus 32 binary digits with padding, plus idle bursts.
  // The limit takes that several times over.
  localparam int IDLE_LIMIT   = 2000;
  // Drain after the last expected character: a 63-char field plus a 32-digit extraction.
  localparam int DRAIN_CYCLES = 250;

  // One expected character of a formatted field.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  // Formats each accepted request on its own and holds the characters still owed.
  class char_scoreboard;
    field_char_t owed[$];
    int          failures;

    function new();
      failures = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Build the full field for one request: pad characters, then digits MSB first.
    function void note_request(logic [31:0] v, radix_mode_t m, logic [5:0] w, logic zp);
      logic [7:0]  digs[$];
      logic [31:0] rest;
      logic [31:0] d;
      int unsigned base;
      int unsigned pad_cnt;
      int unsigned total;
      int unsigned k;
      field_char_t fc;
      case (m)
        MODE_BIN: base = 2;
        MODE_OCT: base = 8;
        MODE_DEC: base = 10;
        default:  base = 16;
      endcase
      rest = v;
      if (rest == 0) begin
        digs.push_front(CHAR_ZERO);
      end
      while (rest != 0) begin
        d = rest % base;
        if (d <= 9) digs.push_front(CHAR_ZERO + d[7:0]);
        else        digs.push_front(CHAR_A + d[7:0] - 8'd10);
        rest = rest / base;
      end
      // 6-bit width never exceeds the 63-character field, so no saturation here
      pad_cnt = (w > digs.size()) ? w - digs.size() : 0;
      total   = pad_cnt + digs.size();
      k = 0;
      repeat (pad_cnt) begin
        k++;
        fc.ch   = zp ? CHAR_ZERO : CHAR_SPACE;
        fc.last = (k == total);
        owed.push_back(fc);
      end
      foreach (digs[i]) begin
        k++;
        fc.ch   = digs[i];
        fc.last = (k == total);
        owed.push_back(fc);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic lst);
      field_char_t exp_c;
      if (owed.size() == 0) begin
        failures++;
        $display("%0t: unexpected character: expected none, actual char=%h last=%b",
                 $realtime, ch, lst);
        return;
      end
      exp_c = owed.pop_front();
      if (ch !== exp_c.ch) begin
        failures++;
        $display("%0t: out_char mismatch: expected %h, actual %h", $realtime, exp_c.ch, ch);
      end
      if (lst !== exp_c.last) begin
        failures++;
        $display("%0t: last mismatch: expected %b, actual %b", $realtime, exp_c.last, lst);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [31:0] value;
  logic [1:0]  mode;
  logic [5:0]  min_width;
  logic        zero_pad;
  logic        char_valid;
  logic        char_stall;
  logic [7:0]  out_char;
  logic        last;

  char_scoreboard sb;
  bit             quiet;        // no idling from here on
  bit             hold_pending; // sender asks the receiver for one long hold-off
  int             sent;

  radix_integer_formatter dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .value      (value),
    .mode       (mode),
    .min_width  (min_width),
    .zero_pad   (zero_pad),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one request. Entered and left at a falling edge; the request is
  // noted at the rising edge where it is accepted.
  task automatic send_request(logic [31:0] v, radix_mode_t m, logic [5:0] w, logic zp);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    if (sent == HOLD_AT) hold_pending = 1'b1;
    req_valid <= 1'b1;
    value     <= v;
    mode      <= m;
    min_width <= w;
    zero_pad  <= zp;
    do @(posedge clk); while (req_stall);
    sb.note_request(v, m, w, zp);
    sent++;
    @(negedge clk);
  endtask

  // Random request: value length spread so short fields appear often, width
  // mostly small with an occasional wide field.
  task automatic send_random();
    logic [32:0] mask;
    logic [31:0] v;
    logic [5:0]  w;
    logic        zp;
    int          nbits;
    nbits = $urandom_range(0, 32);
    mask  = (33'h1 << nbits) - 33'h1;
    v     = $urandom & mask[31:0];
    if ($urandom_range(0, 9) < 7) w = 6'($urandom_range(0, 12));
    else                          w = 6'($urandom_range(0, 63));
    zp = 1'($urandom_range(0, 1));
    send_request(v, radix_mode_t'(2'($urandom_range(0, 3))), w, zp);
  endtask

  // Receiver: random stall bursts, plus one long hold-off so the block backs
  // up and stalls its request side. At most one assignment per falling edge.
  initial begin
    int burst;
    char_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        char_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 3);
        char_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        char_stall <= 1'b0;
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && char_valid && !char_stall) begin
      sb.check_char(out_char, last);
    end
  end

  // Watchdog: cycles in a row with no request or character accepted.
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (char_valid && !char_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d characters still owed", $realtime, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    quiet        = 1'b0;
    hold_pending = 1'b0;
    sent         = 0;
    rst          = 1'b1;
    req_valid    = 1'b0;
    value        = '0;
    mode         = MODE_BIN;
    min_width    = '0;
    zero_pad     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero in every radix, bare and padded
    send_request(32'd0, MODE_BIN, 6'd0, 1'b0);
    send_request(32'd0, MODE_OCT, 6'd0, 1'b1);
    send_request(32'd0, MODE_DEC, 6'd0, 1'b0);
    send_request(32'd0, MODE_HEX, 6'd5, 1'b1);
    send_request(32'd0, MODE_DEC, 6'd4, 1'b0);
    // all ones: longest digit strings
    send_request(32'hFFFF_FFFF, MODE_BIN, 6'd0, 1'b0);
    send_request(32'hFFFF_FFFF, MODE_OCT, 6'd0, 1'b0);
    send_request(32'hFFFF_FFFF, MODE_DEC, 6'd12, 1'b1);
    send_request(32'hFFFF_FFFF, MODE_HEX, 6'd63, 1'b0);
    // every hex letter and digit
    send_request(32'hFEDC_BA98, MODE_HEX, 6'd12, 1'b0);
    send_request(32'h0123_4567, MODE_HEX, 6'd8, 1'b1);
    // width below, equal to and just above the digit count
    send_request(32'd123456, MODE_DEC, 6'd3, 1'b1);
    send_request(32'd12345, MODE_DEC, 6'd5, 1'b0);
    send_request(32'd12345, MODE_DEC, 6'd6, 1'b1);
    // radix boundaries
    send_request(32'd9, MODE_DEC, 6'd1, 1'b0);
    send_request(32'd10, MODE_DEC, 6'd0, 1'b0);
    send_request(32'd8, MODE_OCT, 6'd2, 1'b1);
    send_request(32'd1, MODE_BIN, 6'd63, 1'b1);
    send_request(32'd7, MODE_DEC, 6'd63, 1'b0);
    send_request(32'h8000_0000, MODE_BIN, 6'd40, 1'b1);
    send_request(32'h5555_AAAA, MODE_OCT, 6'd33, 1'b0);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT - QUIET_COUNT) quiet = 1'b1;
      send_random();
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
